FILE: sv/bspl_pkg.sv
package bspl_pkg;

  localparam int unsigned NodeDepth = 4096;
  localparam int unsigned NodeAw    = 12;
  localparam int unsigned CountW    = 13;
  localparam int unsigned LinkW     = 16;
  localparam int unsigned SubW      = 15;

  localparam logic ActWrite = 1'b0;
  localparam logic ActQuery = 1'b1;

  // Walk finish codes for the pending result
  localparam logic [1:0] FinNone  = 2'd0;
  localparam logic [1:0] FinLeaf  = 2'd1;
  localparam logic [1:0] FinErr   = 2'd2;
  localparam logic [1:0] FinEmpty = 2'd3;

  typedef struct packed {
    logic               action;
    logic [NodeAw-1:0]  node_index;
    logic signed [31:0] part_x;
    logic signed [31:0] part_y;
    logic signed [31:0] part_dx;
    logic signed [31:0] part_dy;
    logic [LinkW-1:0]   front_child;
    logic [LinkW-1:0]   back_child;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } bspl_in_t;

  typedef struct packed {
    logic [SubW-1:0] subsector_index;
    logic            walk_error;
  } bspl_out_t;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic [LinkW-1:0]   front;
    logic [LinkW-1:0]   back;
  } bspl_node_t;

  typedef struct packed {
    logic       store_node;
    logic       load_root;
    logic       issue_read;
    logic       calc_diff;
    logic       calc_mul;
    logic       take_step;
    logic [1:0] fin;
    logic       out_load;
  } bspl_cmd_t;

  typedef struct packed {
    logic empty;
    logic is_leaf;
    logic is_bad;
  } bspl_stat_t;

endpackage

FILE: sv/bspl_node_mem.sv
module bspl_node_mem
  import bspl_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [NodeAw-1:0] waddr_i,
  input  bspl_node_t        wdata_i,
  input  logic              re_i,
  input  logic [NodeAw-1:0] raddr_i,
  output bspl_node_t        rdata_o
);

  bspl_node_t mem [NodeDepth];
  bspl_node_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/bspl_datapath.sv
module bspl_datapath
  import bspl_pkg::*;
#(
  parameter int unsigned MAX_NODES = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bspl_cmd_t         cmd_i,
  output bspl_stat_t        stat_o,
  input  bspl_in_t          in_data_i,
  input  logic [CountW-1:0] node_count_i,
  output bspl_out_t         out_data_o
);

  localparam int unsigned StepW = $clog2(MAX_NODES + 1);

  logic [LinkW-1:0]   walk_node_q, walk_node_d;
  logic [StepW-1:0]   steps_q, steps_d;
  logic signed [31:0] px_q, py_q;
  bspl_out_t          pend_q, pend_d;
  bspl_out_t          out_q;

  bspl_node_t         node;
  bspl_node_t         wnode;

  logic signed [31:0] ddx_q, ddy_q, ddx_d, ddy_d;
  logic signed [15:0] dyh_q, dxh_q;
  logic [LinkW-1:0]   front_q, back_q;
  logic               fixed_q, fside_q, fixed_d, fside_d;
  logic signed [31:0] left_q, right_q;
  logic signed [47:0] left_p, right_p;
  logic               sgn, side;

  assign wnode = '{ox: in_data_i.part_x, oy: in_data_i.part_y,
                   dx: in_data_i.part_dx, dy: in_data_i.part_dy,
                   front: in_data_i.front_child, back: in_data_i.back_child};

  bspl_node_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store_node),
    .waddr_i (in_data_i.node_index),
    .wdata_i (wnode),
    .re_i    (cmd_i.issue_read),
    .raddr_i (walk_node_q[NodeAw-1:0]),
    .rdata_o (node)
  );

  // Status for the controller
  assign stat_o.empty   = (node_count_i == '0);
  assign stat_o.is_leaf = walk_node_q[LinkW-1];
  assign stat_o.is_bad  = (walk_node_q >= {{(LinkW-CountW){1'b0}}, node_count_i})
                        || (walk_node_q[LinkW-1:NodeAw] != '0)
                        || (steps_q >= StepW'(MAX_NODES));

  // Side test, first half: differences and decided cases
  always_comb begin
    ddx_d   = px_q - node.ox;
    ddy_d   = py_q - node.oy;
    sgn     = node.dy[31] ^ node.dx[31] ^ ddx_d[31] ^ ddy_d[31];
    fixed_d = 1'b1;
    if (node.dx == '0) begin
      fside_d = (px_q <= node.ox) ? (node.dy > 0) : (node.dy < 0);
    end else if (node.dy == '0) begin
      fside_d = (py_q <= node.oy) ? (node.dx < 0) : (node.dx > 0);
    end else begin
      fixed_d = sgn;
      fside_d = node.dy[31] ^ ddx_d[31];
    end
  end

  assign left_p  = dyh_q * ddx_q;
  assign right_p = ddy_q * dxh_q;
  assign side    = fixed_q ? fside_q : !(right_q < left_q);

  always_comb begin
    walk_node_d = walk_node_q;
    steps_d     = steps_q;
    if (cmd_i.load_root) begin
      walk_node_d = LinkW'(node_count_i - CountW'(1));
      steps_d     = '0;
    end else if (cmd_i.take_step) begin
      walk_node_d = side ? back_q : front_q;
      steps_d     = steps_q + StepW'(1);
    end
  end

  always_comb begin
    pend_d = pend_q;
    case (cmd_i.fin)
      FinLeaf:  pend_d = '{subsector_index: walk_node_q[SubW-1:0], walk_error: 1'b0};
      FinErr:   pend_d = '{subsector_index: '0, walk_error: 1'b1};
      FinEmpty: pend_d = '{subsector_index: '0, walk_error: 1'b0};
      default:  pend_d = pend_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_node_q <= '0;
      steps_q     <= '0;
    end else begin
      walk_node_q <= walk_node_d;
      steps_q     <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (cmd_i.load_root) begin
      px_q <= in_data_i.point_x;
      py_q <= in_data_i.point_y;
    end
    if (cmd_i.calc_diff) begin
      ddx_q   <= ddx_d;
      ddy_q   <= ddy_d;
      dyh_q   <= node.dy[31:16];
      dxh_q   <= node.dx[31:16];
      front_q <= node.front;
      back_q  <= node.back;
      fixed_q <= fixed_d;
      fside_q <= fside_d;
    end
    if (cmd_i.calc_mul) begin
      left_q  <= left_p[47:16];
      right_q <= right_p[47:16];
    end
    if (cmd_i.out_load) begin
      out_q <= pend_q;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: sv/bspl_ctrl.sv
module bspl_ctrl
  import bspl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       in_action_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  bspl_stat_t stat_i,
  output bspl_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StFetch  = 3'd1;
  localparam logic [2:0] StDiff   = 3'd2;
  localparam logic [2:0] StMul    = 3'd3;
  localparam logic [2:0] StDecide = 3'd4;
  localparam logic [2:0] StDone   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.fin   = FinNone;
    in_ready_o  = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_action_i == ActWrite) begin
            cmd_o.store_node = 1'b1;
          end else if (stat_i.empty) begin
            cmd_o.fin = FinEmpty;
            state_d   = StDone;
          end else begin
            cmd_o.load_root = 1'b1;
            state_d         = StFetch;
          end
        end
      end
      StFetch: begin
        if (stat_i.is_leaf) begin
          cmd_o.fin = FinLeaf;
          state_d   = StDone;
        end else if (stat_i.is_bad) begin
          cmd_o.fin = FinErr;
          state_d   = StDone;
        end else begin
          cmd_o.issue_read = 1'b1;
          state_d          = StDiff;
        end
      end
      StDiff: begin
        cmd_o.calc_diff = 1'b1;
        state_d         = StMul;
      end
      StMul: begin
        cmd_o.calc_mul = 1'b1;
        state_d        = StDecide;
      end
      StDecide: begin
        cmd_o.take_step = 1'b1;
        state_d         = StFetch;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/bsp_point_location_top.sv
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_ready_o   | in_data_i  (bspl_in_t: node write or query)
// out     | output    | out_valid_o / out_ready_i | out_data_o (bspl_out_t: subsector, error)
// cfg     | input     | cfg_we_i, no wait         | cfg_wdata_i (node_count)
//
// A node write completes in the idle state. A query is accepted, visits each node,
// then passes a final leaf/error check and loads the result; an empty tree skips the walk.
// The per-visit cost is set by the node memory's registered read, the
// difference stage, the 16x32 multiplier stage and the compare-and-step.
// Reset (rst_ni low, asynchronous) clears node_count, the walk position and
// the controller; the node table is undefined until written.
// A result waiting in the output register does not block node writes; a new
// query is taken but holds in its last stage until the output frees up.
module bsp_point_location_top
  import bspl_pkg::*;
#(
  parameter int unsigned MAX_NODES = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bspl_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bspl_out_t         out_data_o,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i
);

  logic [CountW-1:0] node_count_q;
  bspl_cmd_t         cmd;
  bspl_stat_t        stat;

  // Hold the node count; the root sits at node_count - 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= '0;
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  // Sequence: accept, then fetch/diff/mul/decide per node until a leaf or error (an empty tree skips the walk)
  bspl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_action_i (in_data_i.action),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Node table, side test and result registers
  bspl_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_data_i    (in_data_i),
    .node_count_i (node_count_q),
    .out_data_o   (out_data_o)
  );

endmodule

FILE: sv/bspl_checker.sv
module bspl_checker
  import bspl_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input bspl_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input bspl_out_t out_data_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Drop input ready once a query is taken
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.action == ActQuery) |=> !in_ready_o)
    else $error("input ready stayed high after a query transfer");

  // An errored walk reports subsector zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.walk_error |-> out_data_o.subsector_index == '0)
    else $error("error result with nonzero subsector");

  // A new result appears only while a query is in progress
  a_out_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a walk");

endmodule

bind bsp_point_location_top bspl_checker u_bspl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: bench/testbench.sv
module testbench
  import bspl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Visit bound handed to the block; the predictor uses the same number.
  localparam int unsigned MaxVisits = 4096;
  localparam int unsigned NumRows   = 25;
  localparam int unsigned RandItems = 850;
  localparam int unsigned PhaseLen  = 40;
  // Longest quiet stretch of a correct run: a walk that runs out of visits makes
  // no transfer at all while it runs.
  localparam int unsigned QuietLimit = 100000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned SettleWait = 8;

  localparam bspl_out_t EmptyTree = '{subsector_index: '0, walk_error: 1'b0};
  localparam bspl_out_t WalkFault = '{subsector_index: '0, walk_error: 1'b1};

  typedef enum logic {RowCfg, RowItem} row_kind_e;

  // One line of the directed plan: either a node_count write or an item.
  // Rows with lit set carry their answer; the rest go through the predictor.
  typedef struct packed {
    row_kind_e         kind;
    logic [CountW-1:0] count;
    bspl_in_t          item;
    logic              lit;
    bspl_out_t         want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  bspl_in_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  bspl_out_t         out_data;
  logic              cfg_we = 1'b0;
  logic [CountW-1:0] cfg_wdata = '0;

  // Predictor state: its own copy of the node table and of node_count.
  bspl_node_t        node_table [NodeDepth];
  bit                node_written [NodeDepth];
  logic [CountW-1:0] tree_count = '0;
  bspl_out_t         pending_locs [$];

  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_out = 1'b0;

  plan_row_t plan [NumRows];

  always #2 clk = ~clk;

  bsp_point_location_top #(
    .MAX_NODES(MaxVisits)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // Side of a partition line that a point falls on: 0 front, 1 back.
  function automatic bit pick_side(int px, int py, bspl_node_t n);
    int ox, oy, ndx, ndy, rx, ry, lhs, rhs;
    ox  = n.ox;
    oy  = n.oy;
    ndx = n.dx;
    ndy = n.dy;
    // Axis-aligned partitions need one compare only.
    if (ndx == 0) begin
      return (px <= ox) ? (ndy > 0) : (ndy < 0);
    end
    if (ndy == 0) begin
      return (py <= oy) ? (ndx < 0) : (ndx > 0);
    end
    // Offsets wrap within 32 bits.
    rx = px - ox;
    ry = py - oy;
    // Differing product signs decide the side without multiplying.
    if (ndy[31] ^ ndx[31] ^ rx[31] ^ ry[31]) begin
      return ndy[31] ^ rx[31];
    end
    lhs = int'((longint'(ndy >>> 16) * longint'(rx)) >>> 16);
    rhs = int'((longint'(ry) * longint'(ndx >>> 16)) >>> 16);
    return !(rhs < lhs);
  endfunction

  // Walk the tree from the root and return the subsector or a walk fault.
  function automatic bspl_out_t locate_point(int px, int py);
    logic [LinkW-1:0] at;
    int unsigned      visits;
    bspl_out_t        res;
    bit               done;
    res = EmptyTree;
    if (tree_count == 0) begin
      return res;
    end
    at     = LinkW'(tree_count - 1'b1);
    visits = 0;
    done   = 1'b0;
    while (!done) begin
      if (at[LinkW-1]) begin
        res.subsector_index = at[SubW-1:0];
        done = 1'b1;
      end else if (at >= tree_count || at >= NodeDepth || visits >= MaxVisits) begin
        res  = WalkFault;
        done = 1'b1;
      end else begin
        at = pick_side(px, py, node_table[at[NodeAw-1:0]]) ?
             node_table[at[NodeAw-1:0]].back : node_table[at[NodeAw-1:0]].front;
        visits++;
      end
    end
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  function automatic plan_row_t cfg_row(logic [CountW-1:0] c);
    plan_row_t r;
    r       = '0;
    r.kind  = RowCfg;
    r.count = c;
    return r;
  endfunction

  function automatic plan_row_t node_row(logic [NodeAw-1:0] idx, int ox, int oy, int dx,
                                         int dy, logic [LinkW-1:0] f, logic [LinkW-1:0] b);
    plan_row_t r;
    r                  = '0;
    r.kind             = RowItem;
    r.item.action      = ActWrite;
    r.item.node_index  = idx;
    r.item.part_x      = ox;
    r.item.part_y      = oy;
    r.item.part_dx     = dx;
    r.item.part_dy     = dy;
    r.item.front_child = f;
    r.item.back_child  = b;
    return r;
  endfunction

  function automatic plan_row_t query_row(int px, int py, logic lit, bspl_out_t want);
    plan_row_t r;
    r              = '0;
    r.kind         = RowItem;
    r.item.action  = ActQuery;
    r.item.point_x = px;
    r.item.point_y = py;
    r.lit          = lit;
    r.want         = want;
    return r;
  endfunction

  // Mix full-range values with small offsets and the extremes.
  function automatic int random_coord();
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return int'($urandom);
    endcase
  endfunction

  // Leaf, an out-of-range link, or a written node below idx; keeps every reachable
  // slot written and the tree free of loops.
  function automatic logic [LinkW-1:0] random_link(int unsigned idx);
    int unsigned r, j;
    r = $urandom_range(0, 19);
    if (r < 6) begin
      return {1'b1, SubW'($urandom_range(0, 32767))};
    end
    if (r == 6) begin
      return LinkW'($urandom_range(NodeDepth, 32767));
    end
    if (idx != 0) begin
      repeat (8) begin
        j = $urandom_range(0, idx - 1);
        if (node_written[j]) begin
          return LinkW'(j);
        end
      end
    end
    return {1'b1, SubW'($urandom_range(0, 32767))};
  endfunction

  function automatic bspl_in_t random_node();
    bspl_in_t it;
    it            = '0;
    it.action     = ActWrite;
    // Keep most nodes in a small range so trees grow deep.
    it.node_index = ($urandom_range(0, 4) == 0) ? NodeAw'($urandom_range(0, NodeDepth - 1)) :
                                                  NodeAw'($urandom_range(0, 63));
    it.part_x     = random_coord();
    it.part_y     = random_coord();
    it.part_dx    = random_coord();
    it.part_dy    = random_coord();
    case ($urandom_range(0, 7))
      0: it.part_dx = '0;
      1: it.part_dy = '0;
      default: ;
    endcase
    it.front_child = random_link(it.node_index);
    it.back_child  = random_link(it.node_index);
    it.point_x     = random_coord();
    it.point_y     = random_coord();
    return it;
  endfunction

  // Offer one item after a random gap and hold it until the transfer; then update
  // the predictor or queue the expected location.
  task automatic transfer_item(bspl_in_t it, logic lit, bspl_out_t want);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (it.action == ActWrite) begin
      node_table[it.node_index] = '{ox: it.part_x, oy: it.part_y, dx: it.part_dx,
                                    dy: it.part_dy, front: it.front_child,
                                    back: it.back_child};
      node_written[it.node_index] = 1'b1;
    end else begin
      pending_locs.push_back(lit ? want : locate_point(it.point_x, it.point_y));
    end
  endtask

  // Drain the block, let a last node write settle, then write node_count.
  task automatic set_count(logic [CountW-1:0] c);
    in_valid <= 1'b0;
    while (pending_locs.size() != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we     <= 1'b0;
    tree_count  = c;
  endtask

  // Compare every accepted result with the oldest expected location.
  always @(posedge clk) begin
    bspl_out_t exp_loc;
    if (rst_n && out_valid && out_ready) begin
      if (pending_locs.size() == 0) begin
        report("result with nothing pending, subsector", out_data.subsector_index, -1);
      end else begin
        exp_loc = pending_locs.pop_front();
        if (out_data.subsector_index !== exp_loc.subsector_index) begin
          report("subsector_index", out_data.subsector_index, exp_loc.subsector_index);
        end
        if (out_data.walk_error !== exp_loc.walk_error) begin
          report("walk_error", out_data.walk_error, exp_loc.walk_error);
        end
      end
    end
  end

  // Watchdog: end the run after a long stretch with no transfer on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAIL bsp_point_location_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: stall a random number of cycles per result, or hold off for a
  // long stretch once so results back up into the input.
  initial begin
    int unsigned pause;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_out) begin
        pause    = LongHold;
        hold_out = 1'b0;
      end else begin
        pause = calm ? 0 : $urandom_range(0, 3);
      end
      if (pause != 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    bspl_in_t          it;
    logic [CountW-1:0] count_sel;
    int unsigned       phase, sent, j;

    // Directed plan: empty tree, axis-aligned partitions on both sides, the sign
    // shortcut, the cross-product compare with wrapped offsets, bad child links,
    // a root beyond the table, a loop that runs out of visits, and the full table.
    plan = '{
      query_row(0, 0, 1'b1, EmptyTree),
      node_row(12'd0, 32'h0001_0000, 0, 0, 32'h0001_0000, 16'h8005, 16'h8007),
      cfg_row(13'd1),
      query_row(0, 0, 1'b0, EmptyTree),
      query_row(32'h0002_0000, 32'h8000_0000, 1'b0, EmptyTree),
      node_row(12'd1, 0, 32'hFFFF_0000, 32'hFFFE_0000, 0, 16'h0000, 16'hFFFF),
      cfg_row(13'd2),
      query_row(0, 32'h8000_0000, 1'b0, EmptyTree),
      query_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, EmptyTree),
      node_row(12'd2, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               16'h0001, 16'h8000),
      cfg_row(13'd3),
      query_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, EmptyTree),
      query_row(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, EmptyTree),
      query_row(32'h0000_1234, 32'hFFFF_8000, 1'b0, EmptyTree),
      node_row(12'd3, 0, 0, 32'h0003_0000, 32'h0001_8000, 16'h1000, 16'h7FFF),
      cfg_row(13'd4),
      query_row(0, 0, 1'b1, WalkFault),
      cfg_row(13'h1FFF),
      query_row(0, 0, 1'b1, WalkFault),
      node_row(12'hFFF, 0, 0, 32'hFFFF_FFFF, 32'h0000_0001, 16'h0FFF, 16'h0FFF),
      cfg_row(13'h1000),
      query_row(32'h1234_5678, 32'h8765_4321, 1'b1, WalkFault),
      node_row(12'hFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
               16'hFFFF, 16'h0002),
      query_row(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, EmptyTree),
      query_row(32'hC000_0000, 32'h4000_0000, 1'b0, EmptyTree)
    };

    // Hold reset, then release it once.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NumRows; r++) begin
      if (plan[r].kind == RowCfg) begin
        set_count(plan[r].count);
      end else begin
        transfer_item(plan[r].item, plan[r].lit, plan[r].want);
      end
    end

    // Random phases: pick a root whose slot is written (or an empty or oversized
    // tree now and then), then stream node writes and queries against it.
    phase = 0;
    sent  = 0;
    while (sent < RandItems) begin
      phase++;
      if (phase == 2) begin
        count_sel = '0;
      end else if (phase == 4) begin
        count_sel = CountW'($urandom_range(NodeDepth + 1, 8191));
      end else if ($urandom_range(0, 7) == 0) begin
        count_sel = CountW'(NodeDepth);
      end else begin
        count_sel = 13'd4;
        repeat (16) begin
          j = $urandom_range(0, 63);
          if (node_written[j] && CountW'(j + 1) > count_sel) begin
            count_sel = CountW'(j + 1);
          end
        end
      end
      set_count(count_sel);
      // Run some phases back to back with no idling on either side.
      calm = (phase % 5 == 1);
      if (phase == 3) begin
        hold_out = 1'b1;
      end
      repeat (PhaseLen) begin
        it = random_node();
        if ($urandom_range(0, 9) >= 3) begin
          it.action = ActQuery;
        end
        transfer_item(it, 1'b0, EmptyTree);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // Drain, then let the block idle a while before the verdict.
    while (pending_locs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_locs.size() == 0) begin
      $display("PASS bsp_point_location_top");
    end else begin
      $display("FAIL bsp_point_location_top");
    end
    $finish;
  end

endmodule
